// ----- hw/rtl/b2a_pkg.sv -----
package b2a_pkg;

  // digit store: 20 BCD / hex nibbles, enough for 2^63-1 in decimal
  localparam int NUM_DIGITS  = 20;
  localparam int DIG_W       = 4 * NUM_DIGITS;
  localparam int NDIG_W      = 5;
  localparam int VALUE_W     = 64;
  localparam int MIND_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int BITCNT_W    = 6;
  localparam int MAX_PAD_DEF = 32;
  localparam int OUT_LIMIT   = 32;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 8'h37;  // 'A' - 10

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PAD,
    ST_DIGS
  } state_t;

  typedef struct packed {
    logic load;
    logic dd_step;
    logic norm_step;
    logic pad_calc;
    logic emit_pad;
    logic emit_dig;
  } cmd_t;

  typedef struct packed {
    logic conv_req;
    logic bit_last;
    logic top_zero;
    logic ndig_one;
    logic pad_zero;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = CHAR_ZERO + {4'b0, d};
    end else begin
      r = CHAR_ALPHA_BASE + {4'b0, d};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/binary_to_ascii_radix_formatter.sv -----
// Flow: decimal, positive values run a 64-step bit-serial double-dabble loop before the digits
//   are normalised and emitted; hex, zero or negative values skip it and go straight to normalise.
// Throughput: one number at a time, next accept only once the last digit has gone to the output reg;
//   chars one per cycle while the receiver is ready, none on the step from the pad chars to the digits.
// Reset (rst_n, synchronous, active low): FSM to idle, output beat dropped, radix to decimal.
module binary_to_ascii_radix_formatter #(
  parameter int MAX_PAD = b2a_pkg::MAX_PAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: radix select, 0 = decimal, 1 = upper-case hex
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] value (signed), [69:64] min_digits, [71:70] zero
  // output stream, one character per beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] digit_char
  output logic        out_tlast   // final char of the string
);
  import b2a_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller sequences load -> convert (decimal positives only) -> normalise -> pad -> emit.
  b2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: binary shift register, 20-nibble digit store, counters and output register.
  // Hex digits of non-negative values load straight into the store; decimal ones come from double dabble.
  b2a_dpath #(
    .MAX_PAD (MAX_PAD)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_tdata[VALUE_W-1:0]),
    .in_min_digits (in_tdata[VALUE_W +: MIND_W]),
    .cmd           (cmd),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_char      (out_tdata),
    .out_last      (out_tlast)
  );

endmodule

// ----- hw/rtl/b2a_ctrl.sv -----
module b2a_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  b2a_pkg::sts_t sts,
  output b2a_pkg::cmd_t cmd
);
  import b2a_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.conv_req ? ST_CONV : ST_NORM;
        end
      end
      ST_CONV: begin
        cmd.dd_step = 1'b1;
        if (sts.bit_last) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // strip leading zero digits, always keep one
        if (sts.top_zero && !sts.ndig_one) begin
          cmd.norm_step = 1'b1;
        end else begin
          cmd.pad_calc = 1'b1;
          state_nxt    = ST_PAD;
        end
      end
      ST_PAD: begin
        if (sts.pad_zero) begin
          state_nxt = ST_DIGS;
        end else if (sts.out_free) begin
          cmd.emit_pad = 1'b1;
        end
      end
      ST_DIGS: begin
        if (sts.out_free) begin
          cmd.emit_dig = 1'b1;
          if (sts.ndig_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/b2a_dpath.sv -----
module b2a_dpath #(
  parameter int MAX_PAD = b2a_pkg::MAX_PAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic [b2a_pkg::VALUE_W-1:0]   in_value,
  input  logic [b2a_pkg::MIND_W-1:0]    in_min_digits,
  input  b2a_pkg::cmd_t                 cmd,
  output b2a_pkg::sts_t                 sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [b2a_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);
  import b2a_pkg::*;

  localparam int LIMIT = (MAX_PAD < OUT_LIMIT) ? MAX_PAD : OUT_LIMIT;

  logic                  hex_r;
  logic [VALUE_W-1:0]    bin_r;
  logic [DIG_W-1:0]      dig_r, dig_adj;
  logic [BITCNT_W-1:0]   bitcnt_r;
  logic [NDIG_W-1:0]     ndig_r;
  logic [MIND_W-1:0]     want_r, want_nxt;
  logic [MIND_W-1:0]     padcnt_r;
  logic [MIND_W-1:0]     ndig_ext;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  assign ndig_ext = {1'b0, ndig_r};
  assign want_nxt = (in_min_digits > MIND_W'(LIMIT)) ? MIND_W'(LIMIT) : in_min_digits;

  // double-dabble correction, one lane per digit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        dig_adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_r <= 1'b0;
    end else if (cfg_we) begin
      hex_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r    <= in_value;
      bitcnt_r <= '0;
      ndig_r   <= NDIG_W'(NUM_DIGITS);
      want_r   <= want_nxt;
      if (hex_r && !in_value[VALUE_W-1]) begin
        dig_r <= {{(DIG_W-VALUE_W){1'b0}}, in_value};
      end else begin
        dig_r <= '0;
      end
    end else if (cmd.dd_step) begin
      dig_r    <= {dig_adj[DIG_W-2:0], bin_r[VALUE_W-1]};
      bin_r    <= {bin_r[VALUE_W-2:0], 1'b0};
      bitcnt_r <= bitcnt_r + 1'b1;
    end else if (cmd.norm_step || cmd.emit_dig) begin
      dig_r  <= {dig_r[DIG_W-5:0], 4'b0};
      ndig_r <= ndig_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pad_calc) begin
      padcnt_r <= (want_r > ndig_ext) ? (want_r - ndig_ext) : '0;
    end else if (cmd.emit_pad) begin
      padcnt_r <= padcnt_r - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pad || cmd.emit_dig) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pad) begin
      out_char_r <= CHAR_ZERO;
      out_last_r <= 1'b0;
    end else if (cmd.emit_dig) begin
      out_char_r <= digit_glyph(dig_r[DIG_W-1 -: 4]);
      out_last_r <= (ndig_r == NDIG_W'(1));
    end
  end

  assign sts.conv_req = !hex_r && !in_value[VALUE_W-1] && (|in_value);
  assign sts.bit_last = (bitcnt_r == BITCNT_W'(VALUE_W - 1));
  assign sts.top_zero = (dig_r[DIG_W-1 -: 4] == 4'd0);
  assign sts.ndig_one = (ndig_r == NDIG_W'(1));
  assign sts.pad_zero = (padcnt_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Tracks the digit strings the formatter owes us, oldest first.
class ascii_digit_checker;
  typedef struct {
    logic [7:0] glyph;
    logic       is_last;
  } char_beat_t;

  string        glyph_set = "0123456789ABCDEF";
  bit           hex_mode;
  char_beat_t   due[$];
  int unsigned  errors;

  function new();
    hex_mode = 1'b0;
    errors   = 0;
  endfunction

  function void note_radix(bit hex);
    hex_mode = hex;
  endfunction

  function int unsigned pending();
    return due.size();
  endfunction

  // Spell one accepted number into the characters it should produce.
  function void note_number(logic [63:0] value, logic [5:0] min_digits);
    logic [7:0]  glyphs[$];
    logic [63:0] rest;
    int unsigned base;
    int unsigned cap;
    int unsigned want;
    char_beat_t  beat;
    base = hex_mode ? 16 : 10;
    cap  = (b2a_pkg::MAX_PAD_DEF < b2a_pkg::OUT_LIMIT) ?
           b2a_pkg::MAX_PAD_DEF : b2a_pkg::OUT_LIMIT;
    rest = value;
    if (value[63] || value == '0) begin
      glyphs.push_front("0");
    end else begin
      while (rest != '0) begin
        glyphs.push_front(glyph_set[rest % base]);
        rest = rest / base;
      end
    end
    want = (32'(min_digits) > cap) ? cap : 32'(min_digits);
    while (glyphs.size() < want) begin
      glyphs.push_front("0");
    end
    foreach (glyphs[k]) begin
      beat.glyph   = glyphs[k];
      beat.is_last = (k == glyphs.size() - 1);
      due.insert(due.size(), beat);
    end
  endfunction

  function void check_char(logic [7:0] data, logic last);
    char_beat_t want;
    if (due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected char %h last %b, nothing due", data, last);
      end
      return;
    end
    want = due.pop_front();
    if (data !== want.glyph || last !== want.is_last) begin
      errors++;
      if (errors <= 10) begin
        $display("char mismatch: expected %h last %b, got %h last %b",
                 want.glyph, want.is_last, data, last);
      end
    end
  endfunction
endclass

module tb_top;

  // Generous ceiling: worst case is ~500 numbers x (bit-serial conversion
  // + 32 chars under heavy back-pressure + sender gaps), well under this.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_NUMBERS = 440;
  localparam int unsigned PHASES = 4;

  // receiver back-pressure styles, re-chosen at random by the receiver process
  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // [63:0] value, [69:64] min_digits, [71:70] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] digit_char
  logic        out_tlast;

  ascii_digit_checker book;
  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_tick     = 0;
  rx_mode_t    rx_mode     = RX_FREE;
  logic [15:0] rx_pattern  = '1;
  bit          cur_hex     = 1'b0;

  binary_to_ascii_radix_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake must not hang the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Beat monitor. Both sides are sampled at the edge the handshake lands on;
  // inputs are only ever changed by NBAs at that same edge, so no race.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        book.note_number(in_tdata[63:0], in_tdata[69:64]);
      end
      if (out_tvalid && out_tready) begin
        book.check_char(out_tdata, out_tlast);
      end
    end
  end

  // Receiver: its own stall pattern, independent of the sender.
  // Free-running stretches give back-to-back chars; the others push gaps
  // into the pad and digit emission phases.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 97 == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_pattern = 16'($urandom);
    end
    case (rx_mode)
      RX_FREE:    out_tready <= 1'b1;
      RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE:  out_tready <= (rx_tick % 4 == 0);
      default:    out_tready <= rx_pattern[rx_tick % 16];
    endcase
  end

  // Push one number. The sender runs in bursts; between bursts it drops
  // tvalid for a random gap, occasionally a long one.
  task automatic send_number(input logic [63:0] value, input logic [5:0] min_digits);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, min_digits, value};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // Hold the sender until every owed char is back, then let the FSM settle
  // to idle. The wait starts only once the monitor has booked a number
  // accepted at the edge we were called on.
  task automatic wait_results_home();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Radix may only change with the block idle.
  task automatic set_radix(input bit hex);
    wait_results_home();
    cfg_we    <= 1'b1;
    cfg_wdata <= hex;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.note_radix(hex);
    cur_hex = hex;
  endtask

  // Random number: mostly well-formed positives of all lengths, with
  // radix-power boundaries, negatives and raw 64-bit noise mixed in.
  task automatic send_random_number();
    logic [63:0] value;
    logic [63:0] power;
    logic [5:0]  min_digits;
    int unsigned pick;
    int unsigned exp_k;
    pick = $urandom_range(0, 9);
    value = {$urandom, $urandom};
    case (pick)
      0, 1: value = 64'($urandom_range(0, 4095));
      2, 3: begin
        value[63] = 1'b0;
        value = value >> $urandom_range(0, 62);
      end
      4: begin
        // walk up to base^k, then land on base^k-1, base^k or base^k+1
        exp_k = cur_hex ? $urandom_range(0, 15) : $urandom_range(0, 18);
        power = 64'd1;
        repeat (exp_k) power = power * (cur_hex ? 64'd16 : 64'd10);
        value = power + 64'($urandom_range(0, 2)) - 64'd1;
      end
      5: value[63] = 1'b1;
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      min_digits = 6'($urandom_range(0, 20));
    end else if (pick < 16) begin
      min_digits = 6'($urandom_range(21, 31));
    end else if (pick < 18) begin
      min_digits = 6'd32;
    end else if (pick == 18) begin
      min_digits = 6'($urandom_range(33, 63));  // above the pad cap: saturates
    end else begin
      min_digits = '0;
    end
    send_number(value, min_digits);
  endtask

  initial begin
    book = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, decimal: zero, negatives, both ends of the range, digit-count
    // boundaries, padding to the cap and beyond it.
    set_radix(1'b0);
    send_number(64'd0, 6'd0);
    send_number(64'd0, 6'd32);
    send_number(64'd1, 6'd0);
    send_number(64'd9, 6'd1);
    send_number(64'd10, 6'd0);
    send_number(-64'sd1, 6'd5);
    send_number(64'h8000_0000_0000_0000, 6'd0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd32);
    send_number(64'd999_999_999_999_999_999, 6'd20);
    send_number(64'd1_000_000_000_000_000_000, 6'd0);
    send_number(64'd12345, 6'd63);
    send_number(64'd7, 6'd33);

    // Directed, hex: every letter glyph, pad shorter/longer than the digits.
    set_radix(1'b1);
    send_number(64'd0, 6'd0);
    send_number(64'd15, 6'd0);
    send_number(64'd16, 6'd2);
    send_number(64'h0123_4567_89AB_CDEF, 6'd0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd20);
    send_number(64'hFEDC_BA98_7654_3210, 6'd1);
    send_number(64'h00AB_CDEF, 6'd31);
    send_number(64'd255, 6'd32);
    send_number(64'd1, 6'd63);

    // Random phases, radix flipping between them.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      set_radix(phase[0]);
      for (int unsigned n = 0; n < RANDOM_NUMBERS / PHASES; n++) begin
        // one mid-phase pause with the whole pipe emptied
        if (phase == 1 && n == RANDOM_NUMBERS / (2 * PHASES)) begin
          wait_results_home();
        end
        send_random_number();
      end
    end

    // Drain, then linger so a stray extra char would still be caught.
    wait_results_home();
    repeat (120) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- binary_to_ascii_radix_formatter.f -----
hw/rtl/b2a_pkg.sv
hw/rtl/b2a_ctrl.sv
hw/rtl/b2a_dpath.sv
hw/rtl/binary_to_ascii_radix_formatter.sv
sim/tb_top.sv
